[sv/aes128_block_cipher_fixed_key_assert.svh]
// Assertion macros used by the block's top module
`ifndef AES128_BLOCK_CIPHER_FIXED_KEY_ASSERT_SVH
`define AES128_BLOCK_CIPHER_FIXED_KEY_ASSERT_SVH

// Implication checked on every rising clock edge, off during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[sv/aes128_pkg.sv]
package aes128_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic       load;     // take the input block, add first round key
		logic       step;     // run one round
		logic [3:0] rnd;      // round number, 1..10
		logic       last;     // final round of the direction
	} cmd_t;

	localparam int unsigned NUM_ROUNDS = 10;
	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	localparam logic [127:0] ROUND_KEY [0:10] = '{
		128'h000102030405060708090a0b0c0d0e0f,
		128'hd6aa74fdd2af72fadaa678f1d6ab76fe,
		128'hb692cf0b643dbdf1be9bc5006830b3fe,
		128'hb6ff744ed2c2c9bf6c590cbf0469bf41,
		128'h47f7f7bc95353e03f96c32bcfd058dfd,
		128'h3caaa3e8a99f9deb50f3af57adf622aa,
		128'h5e390f7df7a69296a7553dc10aa31f6b,
		128'h14f9701ae35fe28c440adf4d4ea9c026,
		128'h47438735a41c65b9e016baf4aebf7ad2,
		128'h549932d1f08557681093ed9cbe2c974e,
		128'h13111d7fe3944a17f307a78b4d2b30c5
	};

	localparam logic [7:0] FWD_SBOX [0:255] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SBOX [0:255] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	// Multiply by x in GF(2^8)
	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

endpackage

[sv/aes128_ctrl.sv]
module aes128_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic                out_fire,
	output logic                busy,
	output logic                done,
	output aes128_pkg::cmd_t    cmd
);

	aes128_pkg::state_t state_q, state_d;
	logic [3:0] rnd_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			aes128_pkg::ST_IDLE: if (in_fire) state_d = aes128_pkg::ST_RUN;
			aes128_pkg::ST_RUN: begin
				if (rnd_q == 4'(aes128_pkg::NUM_ROUNDS)) state_d = aes128_pkg::ST_DONE;
			end
			aes128_pkg::ST_DONE: if (out_fire) state_d = aes128_pkg::ST_IDLE;
			default: state_d = aes128_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		busy     = 1'b1;
		done     = 1'b0;
		cmd.load = 1'b0;
		cmd.step = 1'b0;
		cmd.rnd  = rnd_q;
		cmd.last = (rnd_q == 4'(aes128_pkg::NUM_ROUNDS));
		case (state_q)
			aes128_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = in_fire;
			end
			aes128_pkg::ST_RUN:  cmd.step = 1'b1;
			aes128_pkg::ST_DONE: done = 1'b1;
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aes128_pkg::ST_IDLE;
			rnd_q   <= 4'd1;
		end else begin
			state_q <= state_d;
			if (cmd.step) rnd_q <= cmd.last ? 4'd1 : rnd_q + 4'd1;
		end
	end

endmodule

[sv/aes128_datapath.sv]
module aes128_datapath (
	input  logic             clk,
	input  aes128_pkg::cmd_t cmd,
	input  logic             command,
	input  logic [127:0]     block,
	output logic [127:0]     result
);

	logic [127:0] st_q;
	logic         dec_q;
	logic [127:0] subbed, mixed, keyed, rkey, nxt;

	// Round key: forward uses rnd, inverse uses 10 - rnd
	assign rkey = dec_q ? aes128_pkg::ROUND_KEY[4'd10 - cmd.rnd]
	                    : aes128_pkg::ROUND_KEY[cmd.rnd];

	// Byte i sits at bits 127-8i; row = i%4, col = i/4
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				automatic int src = dec_q ? ((c - r + 4) & 3) : ((c + r) & 3);
				automatic logic [7:0] b = st_q[127 - 8*(r + 4*src) -: 8];
				subbed[127 - 8*(r + 4*c) -: 8] =
					dec_q ? aes128_pkg::INV_SBOX[b] : aes128_pkg::FWD_SBOX[b];
			end
		end
	end

	// Forward: mix then key; inverse: key then mix
	always_comb begin
		logic [127:0] pre;
		logic [7:0] a [0:3];
		logic [7:0] x2 [0:3];
		logic [7:0] x4 [0:3];
		logic [7:0] x8 [0:3];
		pre = dec_q ? (subbed ^ rkey) : subbed;
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				a[k]  = pre[127 - 8*(k + 4*c) -: 8];
				x2[k] = aes128_pkg::xtime(a[k]);
				x4[k] = aes128_pkg::xtime(x2[k]);
				x8[k] = aes128_pkg::xtime(x4[k]);
			end
			for (int r = 0; r < 4; r++) begin
				if (dec_q)
					mixed[127 - 8*(r + 4*c) -: 8] =
						(x8[r] ^ x4[r] ^ x2[r]) ^
						(x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4]) ^
						(x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4]) ^
						(x8[(r+3)%4] ^ a[(r+3)%4]);
				else
					mixed[127 - 8*(r + 4*c) -: 8] =
						x2[r] ^ (x2[(r+1)%4] ^ a[(r+1)%4]) ^ a[(r+2)%4] ^ a[(r+3)%4];
			end
		end
		if (dec_q) keyed = cmd.last ? pre : mixed;
		else       keyed = (cmd.last ? subbed : mixed) ^ rkey;
	end

	assign nxt = keyed;

	// State register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dec_q <= command;
			st_q  <= block ^ (command ? aes128_pkg::ROUND_KEY[10] : aes128_pkg::ROUND_KEY[0]);
		end else if (cmd.step) begin
			st_q <= nxt;
		end
	end

	assign result = st_q;

endmodule

[sv/aes128_block_cipher_fixed_key.sv]
// AES-128 encrypt/decrypt core with a fixed built-in key schedule.
// s_axis carries one item: tuser = command (0 encrypt, 1 decrypt) and
// tdata = {block_low, block_high}. m_axis returns tdata = {result_low,
// result_high}, byte 0 of the block in bits 63..56 of the high half.
// One shared round unit does the work: the first key add happens as
// the item is accepted, then ten rounds run one per cycle.
// tvalid rises once the last round has been registered; the result can be
// taken in the first cycle that it is valid, and the core then returns to
// idle before the next item can be accepted.
// One item is in flight at a time; s_axis_tready is low until the result
// has been taken. While m_axis_tready is low the result holds stable.
// arst_n clears the controller; no item is in flight after reset.
`include "aes128_block_cipher_fixed_key_assert.svh"
module aes128_block_cipher_fixed_key (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // block_high[63:0], block_low[127:64]
	input  logic         s_axis_tuser,  // command
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata   // result_high[63:0], result_low[127:64]
);

	aes128_pkg::cmd_t cmd;
	logic busy, done, in_fire, out_fire;
	logic [127:0] res;

	assign s_axis_tready = !busy;
	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;
	assign m_axis_tvalid = done;
	assign m_axis_tdata  = {res[63:0], res[127:64]};

	aes128_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.busy(busy), .done(done), .cmd(cmd)
	);

	aes128_datapath u_dp (
		.clk(clk), .cmd(cmd), .command(s_axis_tuser),
		.block({s_axis_tdata[63:0], s_axis_tdata[127:64]}), .result(res)
	);

	`ASSERT_IMPLIES(a_no_accept_busy, clk, arst_n, m_axis_tvalid, !s_axis_tready)
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, in_fire, busy)
	`ASSERT_IMPLIES(a_load_idle, clk, arst_n, cmd.load, !cmd.step)

endmodule
